// ===== hdl/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, constants and opcode codes of the stack bytecode executor.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

	localparam int WORD_W          = 32;
	localparam int SP_W            = 7;
	localparam int PC_W            = 16;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int LOCAL_DEPTH_DEF = 256;

	// configuration register reset values
	localparam logic [6:0]  LIMIT_RST  = 7'd64;
	localparam logic [8:0]  LOCALS_RST = 9'd256;
	localparam logic [15:0] CODE_RST   = 16'hffff;
	localparam logic [15:0] BUDGET_RST = 16'd10000;

	// register indexes on the apb port
	localparam logic [1:0] REG_STACK_LIMIT = 2'd0;
	localparam logic [1:0] REG_LOCALS      = 2'd1;
	localparam logic [1:0] REG_CODE_LEN    = 2'd2;
	localparam logic [1:0] REG_BUDGET      = 2'd3;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_FAULT     = 3'd3,
		ST_BUDGET    = 3'd4
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [PC_W-1:0]      pc;
		logic                 done;
		logic [WORD_W-1:0]    rv;
		logic                 rvalid;
		logic [SP_W-1:0]      depth;
	} result_t;

	// opcodes
	localparam logic [7:0] OP_NOP      = 8'h00;
	localparam logic [7:0] OP_ACONST   = 8'h01;
	localparam logic [7:0] OP_ICONST_M = 8'h02;
	localparam logic [7:0] OP_ICONST_5 = 8'h08;
	localparam logic [7:0] OP_BIPUSH   = 8'h10;
	localparam logic [7:0] OP_SIPUSH   = 8'h11;
	localparam logic [7:0] OP_ILOAD    = 8'h15;
	localparam logic [7:0] OP_ILOAD_0  = 8'h1a;
	localparam logic [7:0] OP_ILOAD_3  = 8'h1d;
	localparam logic [7:0] OP_ALOAD_0  = 8'h2a;
	localparam logic [7:0] OP_ALOAD_3  = 8'h2d;
	localparam logic [7:0] OP_ISTORE   = 8'h36;
	localparam logic [7:0] OP_ISTORE_0 = 8'h3b;
	localparam logic [7:0] OP_ISTORE_3 = 8'h3e;
	localparam logic [7:0] OP_ASTORE_0 = 8'h4b;
	localparam logic [7:0] OP_ASTORE_3 = 8'h4e;
	localparam logic [7:0] OP_POP      = 8'h57;
	localparam logic [7:0] OP_POP2     = 8'h58;
	localparam logic [7:0] OP_DUP      = 8'h59;
	localparam logic [7:0] OP_SWAP     = 8'h5f;
	localparam logic [7:0] OP_IADD     = 8'h60;
	localparam logic [7:0] OP_ISUB     = 8'h64;
	localparam logic [7:0] OP_IMUL     = 8'h68;
	localparam logic [7:0] OP_IDIV     = 8'h6c;
	localparam logic [7:0] OP_IREM     = 8'h70;
	localparam logic [7:0] OP_INEG     = 8'h74;
	localparam logic [7:0] OP_ISHL     = 8'h78;
	localparam logic [7:0] OP_ISHR     = 8'h7a;
	localparam logic [7:0] OP_IUSHR    = 8'h7c;
	localparam logic [7:0] OP_IAND     = 8'h7e;
	localparam logic [7:0] OP_IOR      = 8'h80;
	localparam logic [7:0] OP_IXOR     = 8'h82;
	localparam logic [7:0] OP_IFEQ     = 8'h99;
	localparam logic [7:0] OP_IFNE     = 8'h9a;
	localparam logic [7:0] OP_IFLT     = 8'h9b;
	localparam logic [7:0] OP_IFGE     = 8'h9c;
	localparam logic [7:0] OP_IFGT     = 8'h9d;
	localparam logic [7:0] OP_IFLE     = 8'h9e;
	localparam logic [7:0] OP_ICMPEQ   = 8'h9f;
	localparam logic [7:0] OP_ICMPNE   = 8'ha0;
	localparam logic [7:0] OP_GOTO     = 8'ha7;
	localparam logic [7:0] OP_IRETURN  = 8'hac;
	localparam logic [7:0] OP_RETURN   = 8'hb1;

endpackage

`default_nettype wire

// ===== hdl/sbe_ram.sv =====
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/sbe_div.sv =====
// ----------------------------------------------------------------------------
// sbe_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_div
	import sbe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] dividend,
	input  wire logic [WORD_W-1:0] divisor,
	output logic                   done,
	output logic      [WORD_W-1:0] quotient,
	output logic      [WORD_W-1:0] remainder
);

	localparam int CW = $clog2(WORD_W + 1);

	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              fin_q;
	logic              done_q;
	logic              negq_q;
	logic              negr_q;
	logic [WORD_W-1:0] q_q;
	logic [WORD_W-1:0] r_q;
	logic [WORD_W-1:0] d_q;
	logic [WORD_W-1:0] quot_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] rsh;
	logic              fits;

	// one shift-subtract step
	assign rsh  = {r_q[WORD_W-2:0], q_q[WORD_W-1]};
	assign fits = (rsh >= d_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				cnt_q <= CW'(WORD_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// datapath on magnitudes, signs applied at the end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= dividend[WORD_W-1] ? (-dividend) : dividend;
			d_q    <= divisor[WORD_W-1] ? (-divisor) : divisor;
			r_q    <= '0;
			negq_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			negr_q <= dividend[WORD_W-1];
		end else if (run_q) begin
			r_q <= fits ? (rsh - d_q) : rsh;
			q_q <= {q_q[WORD_W-2:0], fits};
		end
		if (fin_q) begin
			quot_q <= negq_q ? (-q_q) : q_q;
			rem_q  <= negr_q ? (-r_q) : r_q;
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hdl/stack_bytecode_executor_unit.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_executor_unit
// Executes one instruction of an integer stack bytecode per input word,
// keeping operand stack and locals in synchronous memories.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid/in_ready, action..this_present  | in
//  result  | out_valid/out_ready, status..stack_depth | out
//  config  | apb psel/penable/pwrite/paddr/pwdata     | in/out
//
//  An instruction passes fetch (stack top latched, optional second stack
//  read), execute with write back, and result before the next accept.
//  swap adds a state for its second write; idiv and irem wait on the
//  bit-serial divider. Reset clears control state and local valid bits at
//  once; a start word clears them, local 0 kept valid with this_present. A
//  new word is taken while a result waits; a stall holds only the result state.
//
`default_nettype none

module stack_bytecode_executor_unit
	import sbe_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int LOCAL_DEPTH = LOCAL_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  opcode,
	input  wire logic [7:0]  operand_high,
	input  wire logic [7:0]  operand_low,
	input  wire logic [31:0] this_ref,
	input  wire logic        this_present,
	// result words
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      next_pc,
	output logic             method_done,
	output logic [31:0]      return_value,
	output logic             return_valid,
	output logic [6:0]       stack_depth,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LAW = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
	localparam int SDC = (STACK_DEPTH > 127) ? 127 : STACK_DEPTH;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_EX, S_DIV, S_SWAP, S_OUT
	} state_t;

	state_t            state_q;
	logic [6:0]        limit_q;
	logic [8:0]        locals_q;
	logic [15:0]       codelen_q;
	logic [15:0]       budget_q;
	logic [SP_W-1:0]   sp_q;
	logic [PC_W-1:0]   pc_q;
	logic [15:0]       cnt_q;
	logic              done_q;
	logic [LOCAL_DEPTH-1:0] lvalid_q;
	result_t           res_q;
	result_t           out_q;
	logic              out_valid_q;

	// latched input word and stack top
	logic              act_q;
	logic [7:0]        op_q;
	logic [7:0]        hi_q;
	logic [7:0]        lo_q;
	logic [31:0]       ref_q;
	logic              pres_q;
	logic [31:0]       top_q;

	// local index carried by the opcode, else by the high operand byte
	function automatic logic [7:0] lidx(input logic [7:0] op, input logic [7:0] hi);
		logic [7:0] r;
		case (op) inside
			[OP_ILOAD_0:OP_ILOAD_3]:   r = op - OP_ILOAD_0;
			[OP_ALOAD_0:OP_ALOAD_3]:   r = op - OP_ALOAD_0;
			[OP_ISTORE_0:OP_ISTORE_3]: r = op - OP_ISTORE_0;
			[OP_ASTORE_0:OP_ASTORE_3]: r = op - OP_ASTORE_0;
			default:                   r = hi;
		endcase
		return r;
	endfunction

	logic [SP_W-1:0]   us;
	logic [8:0]        ul;
	logic [7:0]        idx;
	logic [LAW-1:0]    loc_raddr;
	logic [31:0]       loc_rdata;
	logic [31:0]       lval;
	logic [SAW-1:0]    stk_raddr;
	logic [31:0]       stk_rdata;
	logic              need2;
	logic [15:0]       off;
	logic [31:0]       a_v;
	logic [31:0]       b_v;
	logic [31:0]       prod;
	logic [31:0]       bin_r;
	logic              test_z;
	logic              div_done;
	logic [31:0]       div_q;
	logic [31:0]       div_r;

	// execute outcome
	logic              c_commit;
	status_t           c_st;
	logic [SP_W-1:0]   c_sp;
	logic [PC_W-1:0]   c_pc;
	logic              c_done;
	logic [31:0]       c_rv;
	logic              c_rvalid;
	logic              c_count;
	logic              c_start;
	logic              push_req;
	logic [SP_W-1:0]   push_base;
	logic [31:0]       push_v;
	logic              div_go;
	logic              swap_go;
	logic              stk_we;
	logic [SP_W-1:0]   stk_wa;
	logic [31:0]       stk_wd;
	logic              loc_we;
	logic [7:0]        loc_wa;
	logic [31:0]       loc_wd;

	assign us  = (limit_q < SP_W'(SDC)) ? limit_q : SP_W'(SDC);
	assign ul  = (locals_q < 9'(LOCAL_DEPTH)) ? locals_q : 9'(LOCAL_DEPTH);
	assign idx = lidx(op_q, hi_q);
	assign off = {hi_q, lo_q};

	// local read: address from the port while idle, then from the held word
	assign loc_raddr = (state_q == S_IDLE) ? LAW'(lidx(opcode, operand_high)) : LAW'(idx);
	assign lval      = lvalid_q[LAW'(idx)] ? loc_rdata : 32'd0;

	// operations that need the second stack entry
	always_comb begin
		case (op_q) inside
			OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR,
			OP_IUSHR, OP_IAND, OP_IOR, OP_IXOR, OP_SWAP, OP_ICMPEQ, OP_ICMPNE:
				need2 = 1'b1;
			default: need2 = 1'b0;
		endcase
	end

	assign stk_raddr = (state_q == S_FETCH && need2) ? SAW'(sp_q - SP_W'(2))
	                                                : SAW'(sp_q - SP_W'(1));

	// memories
	sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (SAW'(stk_wa)),
		.wdata (stk_wd),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	sbe_ram #(.WIDTH(32), .DEPTH(LOCAL_DEPTH)) u_locals (
		.clk   (clk),
		.we    (loc_we),
		.waddr (LAW'(loc_wa)),
		.wdata (loc_wd),
		.raddr (loc_raddr),
		.rdata (loc_rdata)
	);

	sbe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (a_v),
		.divisor   (b_v),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// two-operand alu: a is the lower entry, b the top
	assign a_v  = stk_rdata;
	assign b_v  = top_q;
	assign prod = a_v * b_v;

	always_comb begin
		case (op_q) inside
			OP_IADD:  bin_r = a_v + b_v;
			OP_ISUB:  bin_r = a_v - b_v;
			OP_IMUL:  bin_r = prod;
			OP_ISHL:  bin_r = a_v << b_v[4:0];
			OP_ISHR:  bin_r = $unsigned($signed(a_v) >>> b_v[4:0]);
			OP_IUSHR: bin_r = a_v >> b_v[4:0];
			OP_IAND:  bin_r = a_v & b_v;
			OP_IOR:   bin_r = a_v | b_v;
			default:  bin_r = a_v ^ b_v;
		endcase
	end

	// zero compare on the popped top
	always_comb begin
		case (op_q) inside
			OP_IFEQ: test_z = (top_q == 32'd0);
			OP_IFNE: test_z = (top_q != 32'd0);
			OP_IFLT: test_z = top_q[31];
			OP_IFGE: test_z = !top_q[31];
			OP_IFGT: test_z = !top_q[31] && (top_q != 32'd0);
			default: test_z = top_q[31] || (top_q == 32'd0);
		endcase
	end

	// instruction execute
	always_comb begin
		c_commit  = 1'b0;
		c_st      = ST_OK;
		c_sp      = sp_q;
		c_pc      = pc_q + 16'd1;
		c_done    = done_q;
		c_rv      = 32'd0;
		c_rvalid  = 1'b0;
		c_count   = 1'b0;
		c_start   = 1'b0;
		push_req  = 1'b0;
		push_base = sp_q;
		push_v    = 32'd0;
		div_go    = 1'b0;
		swap_go   = 1'b0;
		stk_we    = 1'b0;
		stk_wa    = sp_q;
		stk_wd    = 32'd0;
		loc_we    = 1'b0;
		loc_wa    = idx;
		loc_wd    = top_q;

		case (state_q)
			S_EX: begin
				c_commit = 1'b1;
				if (!act_q) begin
					c_start = 1'b1;
					c_sp    = '0;
					c_pc    = '0;
					c_done  = 1'b0;
					loc_we  = pres_q;
					loc_wa  = 8'd0;
					loc_wd  = ref_q;
				end else if (done_q || pc_q >= codelen_q) begin
					c_pc = pc_q;
				end else if (cnt_q >= budget_q) begin
					c_pc = pc_q;
					c_st = ST_BUDGET;
				end else begin
					c_count = 1'b1;
					case (op_q) inside
						OP_NOP: ;
						OP_ACONST: push_req = 1'b1;
						[OP_ICONST_M:OP_ICONST_5]: begin
							push_req = 1'b1;
							push_v   = {24'd0, op_q} - 32'd3;
						end
						OP_BIPUSH: begin
							c_pc     = pc_q + 16'd2;
							push_req = 1'b1;
							push_v   = {{24{hi_q[7]}}, hi_q};
						end
						OP_SIPUSH: begin
							c_pc     = pc_q + 16'd3;
							push_req = 1'b1;
							push_v   = {{16{hi_q[7]}}, off};
						end
						OP_ILOAD, [OP_ILOAD_0:OP_ILOAD_3], [OP_ALOAD_0:OP_ALOAD_3]: begin
							if (op_q == OP_ILOAD) c_pc = pc_q + 16'd2;
							if ({1'b0, idx} >= ul) begin
								c_st = ST_UNDERFLOW;
							end else begin
								push_req = 1'b1;
								push_v   = lval;
							end
						end
						OP_ISTORE, [OP_ISTORE_0:OP_ISTORE_3], [OP_ASTORE_0:OP_ASTORE_3]: begin
							if (op_q == OP_ISTORE) c_pc = pc_q + 16'd2;
							if (sp_q == '0) begin
								c_st = ST_UNDERFLOW;
							end else begin
								c_sp = sp_q - SP_W'(1);
								if ({1'b0, idx} >= ul) c_st = ST_UNDERFLOW;
								else loc_we = 1'b1;
							end
						end
						OP_POP, OP_INEG, OP_IRETURN,
						OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE: begin
							if (sp_q == '0) begin
								c_st = ST_UNDERFLOW;
							end else begin
								c_sp = sp_q - SP_W'(1);
								if (op_q == OP_INEG) begin
									push_req  = 1'b1;
									push_base = sp_q - SP_W'(1);
									push_v    = 32'd0 - top_q;
								end else if (op_q == OP_IRETURN) begin
									c_rv     = top_q;
									c_rvalid = 1'b1;
									c_done   = 1'b1;
								end else if (op_q != OP_POP) begin
									c_pc = test_z ? (pc_q + off) : (pc_q + 16'd3);
								end
							end
						end
						OP_POP2: begin
							if (sp_q == '0) begin
								c_st = ST_UNDERFLOW;
							end else if (sp_q == SP_W'(1)) begin
								c_sp = '0;
								c_st = ST_UNDERFLOW;
							end else begin
								c_sp = sp_q - SP_W'(2);
							end
						end
						OP_DUP: begin
							if (sp_q == '0) begin
								c_st = ST_UNDERFLOW;
							end else begin
								push_req = 1'b1;
								push_v   = top_q;
							end
						end
						OP_SWAP: begin
							if (sp_q < SP_W'(2)) begin
								c_st = ST_UNDERFLOW;
							end else begin
								// top gets the lower entry now, the lower one next cycle
								c_commit = 1'b0;
								swap_go  = 1'b1;
								stk_we   = 1'b1;
								stk_wa   = sp_q - SP_W'(1);
								stk_wd   = a_v;
							end
						end
						OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR,
						OP_IUSHR, OP_IAND, OP_IOR, OP_IXOR, OP_ICMPEQ, OP_ICMPNE: begin
							if (sp_q == '0) begin
								c_st = ST_UNDERFLOW;
							end else if (sp_q == SP_W'(1)) begin
								c_sp = '0;
								c_st = ST_UNDERFLOW;
							end else begin
								c_sp = sp_q - SP_W'(2);
								if (op_q == OP_ICMPEQ || op_q == OP_ICMPNE) begin
									c_pc = (((a_v == b_v) ? 1'b1 : 1'b0) == (op_q == OP_ICMPEQ))
										? (pc_q + off) : (pc_q + 16'd3);
								end else if (op_q == OP_IDIV || op_q == OP_IREM) begin
									if (b_v == 32'd0) begin
										c_st = ST_FAULT;
									end else begin
										c_commit = 1'b0;
										div_go   = 1'b1;
									end
								end else begin
									push_req  = 1'b1;
									push_base = sp_q - SP_W'(2);
									push_v    = bin_r;
								end
							end
						end
						OP_GOTO:   c_pc = pc_q + off;
						OP_RETURN: c_done = 1'b1;
						default:   c_st = ST_FAULT;
					endcase
				end
			end
			S_DIV: begin
				if (div_done) begin
					c_commit = 1'b1;
					c_count  = 1'b1;
					push_req = 1'b1;
					push_v   = (op_q == OP_IREM) ? div_r : div_q;
				end
			end
			S_SWAP: begin
				c_commit = 1'b1;
				c_count  = 1'b1;
				stk_we   = 1'b1;
				stk_wa   = sp_q - SP_W'(2);
				stk_wd   = top_q;
			end
			default: ;
		endcase

		// push with overflow check
		if (push_req && c_st == ST_OK) begin
			if (push_base >= us) begin
				c_st = ST_OVERFLOW;
			end else begin
				stk_we = 1'b1;
				stk_wa = push_base;
				stk_wd = push_v;
				c_sp   = push_base + SP_W'(1);
			end
		end
		if (c_st != ST_OK) c_count = 1'b0;
	end

	// control state, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= LIMIT_RST;
			locals_q    <= LOCALS_RST;
			codelen_q   <= CODE_RST;
			budget_q    <= BUDGET_RST;
			sp_q        <= '0;
			pc_q        <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			lvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_STACK_LIMIT: limit_q   <= pwdata[6:0];
					REG_LOCALS:      locals_q  <= pwdata[8:0];
					REG_CODE_LEN:    codelen_q <= pwdata[15:0];
					REG_BUDGET:      budget_q  <= pwdata[15:0];
					default: ;
				endcase
			end

			// result word valid
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_FETCH;
				S_FETCH: state_q <= S_EX;
				S_EX: begin
					if (div_go) begin
						sp_q    <= sp_q - SP_W'(2);
						state_q <= S_DIV;
					end else if (swap_go) begin
						state_q <= S_SWAP;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: ;
			endcase

			// commit of one instruction
			if (c_commit) begin
				sp_q    <= c_sp;
				pc_q    <= c_pc;
				done_q  <= c_done;
				state_q <= S_OUT;
				if (c_start) cnt_q <= '0;
				else if (c_count) cnt_q <= cnt_q + 16'd1;
				if (c_start) begin
					lvalid_q <= {{(LOCAL_DEPTH-1){1'b0}}, pres_q};
				end else if (loc_we) begin
					lvalid_q[LAW'(loc_wa)] <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q  <= action;
			op_q   <= opcode;
			hi_q   <= operand_high;
			lo_q   <= operand_low;
			ref_q  <= this_ref;
			pres_q <= this_present;
		end
		if (state_q == S_FETCH) top_q <= stk_rdata;
		if (c_commit) begin
			res_q.status <= c_st;
			res_q.pc     <= c_pc;
			res_q.done   <= c_done || (c_pc >= codelen_q);
			res_q.rv     <= c_rv;
			res_q.rvalid <= c_rvalid;
			res_q.depth  <= c_sp;
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) out_q <= res_q;
	end

	// configuration read back
	always_comb begin
		case (paddr[3:2])
			REG_STACK_LIMIT: prdata = {25'd0, limit_q};
			REG_LOCALS:      prdata = {23'd0, locals_q};
			REG_CODE_LEN:    prdata = {16'd0, codelen_q};
			REG_BUDGET:      prdata = {16'd0, budget_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign pready       = 1'b1;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign next_pc      = out_q.pc;
	assign method_done  = out_q.done;
	assign return_value = out_q.rv;
	assign return_valid = out_q.rvalid;
	assign stack_depth  = out_q.depth;

endmodule

`default_nettype wire
